// File: rtl/core/assert_macros.svh
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define HSFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/hsfd_pkg.sv
// types, constants and crc helper for the humidity sensor frame decoder
package hsfd_pkg;

   localparam int RAW_W   = 16;
   localparam int CRC_W   = 8;
   localparam int PROD_W  = 31;
   localparam int TEMP_W  = 15;
   localparam int HUM_W   = 14;
   localparam int PACK_W  = 24;
   localparam int SCALE_W = 17;
   localparam int QUOT_W  = 11;
   localparam int RECIP_W = 16;
   localparam int RND_W   = 30;

   localparam logic [CRC_W-1:0]   CRC_POLY       = 8'h31;
   localparam logic [CRC_W-1:0]   CRC_INIT       = 8'hFF;
   localparam logic [PACK_W-1:0]  INVALID_PACKED = 24'hFFFFFF;

   localparam logic [PROD_W-1:0]  TEMP_SPAN  = 31'd17500;
   localparam logic [PROD_W-1:0]  HUM_SPAN   = 31'd12500;
   localparam logic [15:0]        TEMP_OFFSET = 16'd4500;
   localparam logic [15:0]        HUM_OFFSET  = 16'd600;
   localparam logic [16:0]        FULL_SCALE  = 17'd65535;

   localparam logic [HUM_W-1:0]   HUM_CENTI_MAX = 14'd10000;
   localparam logic [RECIP_W-1:0] RECIP_TEN     = 16'd52429;
   localparam int                 RECIP_SHIFT   = 19;
   localparam logic [HUM_W-1:0]   ROUND_HALF    = 14'd5;

   localparam logic signed [11:0] TEMP_DECI_MIN = -12'sd400;
   localparam logic signed [11:0] TEMP_DECI_MAX = 12'sd1250;
   localparam logic [9:0]         HUM_DECI_MAX  = 10'd1000;

   // one byte through the msb-first crc-8 shift register
   function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/hsfd_convert.sv
// divide-by-full-scale, offset and truncation toward zero for both words; humidity is clamped to 0..10000
module hsfd_convert
   import hsfd_pkg::*;
(
   input  logic [PROD_W-1:0]        prod_temp,
   input  logic [PROD_W-1:0]        prod_hum,
   output logic signed [TEMP_W-1:0] temp_scaled,
   output logic [HUM_W-1:0]         hum_centi
);

   // floor(prod/65535) from prod>>16 plus one correction, then offset;
   // negative results round up when a remainder is left (toward zero)
   function automatic logic signed [SCALE_W-1:0] scale(input logic [PROD_W-1:0] prod,
                                                       input logic [15:0] offset);
      logic [14:0] q0;
      logic [16:0] rem0;
      logic [16:0] rem;
      logic [15:0] q;
      logic        nz;
      q0   = prod[PROD_W-1:16];
      rem0 = {1'b0, prod[15:0]} + {2'b00, q0};
      if (rem0 >= FULL_SCALE) begin
         q   = {1'b0, q0} + 16'd1;
         rem = rem0 - FULL_SCALE;
      end else begin
         q   = {1'b0, q0};
         rem = rem0;
      end
      nz = (rem != 17'd0) && (q < offset);
      return signed'({1'b0, q}) - signed'({1'b0, offset}) + signed'({16'd0, nz});
   endfunction

   logic signed [SCALE_W-1:0] temp_full;
   logic signed [SCALE_W-1:0] hum_full;

   always_comb begin
      temp_full   = scale(prod_temp, TEMP_OFFSET);
      hum_full    = scale(prod_hum, HUM_OFFSET);
      temp_scaled = temp_full[TEMP_W-1:0];
      if (hum_full < 0) begin
         hum_centi = '0;
      end else if (hum_full > signed'({3'b000, HUM_CENTI_MAX})) begin
         hum_centi = HUM_CENTI_MAX;
      end else begin
         hum_centi = hum_full[HUM_W-1:0];
      end
   end

endmodule

// File: rtl/core/humidity_sensor_frame_decode.sv
// top level: crc check, scaling, rounding and packing of one sensor readout
//
//   channel   direction  handshake            beat
//   req_*     in         start high, busy low  two raw words with their crc bytes
//   rsp_*     out        rsp_strobe, 1 cycle   check flag, centi values, packed word
//
// one readout per cycle while busy is low; each result passes, after its accept, through
// the input register, crc high byte + span multiply, divide + crc low byte and rounding
// busy follows reset and is low otherwise
// reset clears the stage valid bits only, payload registers are not reset
// the receiver takes every result on its strobe cycle and cannot stall
module humidity_sensor_frame_decode
   import hsfd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [RAW_W-1:0]         req_raw_temperature,
   input  logic [CRC_W-1:0]         req_temperature_check,
   input  logic [RAW_W-1:0]         req_raw_humidity,
   input  logic [CRC_W-1:0]         req_humidity_check,
   output logic                     rsp_strobe,
   output logic                     rsp_check_ok,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic [HUM_W-1:0]         rsp_humidity_centi,
   output logic [PACK_W-1:0]        rsp_packed_reading
);

`include "assert_macros.svh"

   // stage 0: input register
   logic             v0_ff, v0_in;
   logic [RAW_W-1:0] raw_t0_ff, raw_h0_ff;
   logic [CRC_W-1:0] chk_t0_ff, chk_h0_ff;

   // stage 1: crc over high byte, span products
   logic              v1_ff;
   logic [CRC_W-1:0]  crc_t1_ff, crc_t1_in, crc_h1_ff, crc_h1_in;
   logic [7:0]        lo_t1_ff, lo_h1_ff;
   logic [CRC_W-1:0]  chk_t1_ff, chk_h1_ff;
   logic [PROD_W-1:0] prod_t1_ff, prod_t1_in, prod_h1_ff, prod_h1_in;

   // stage 2: crc verdict and centi values
   logic                     v2_ff;
   logic                     ok2_ff, ok2_in;
   logic signed [TEMP_W-1:0] t_centi2_ff, t_centi2_in, t_conv;
   logic [HUM_W-1:0]         h_centi2_ff, h_centi2_in, h_conv;

   // result register
   logic                     rsp_strobe_ff;
   logic                     rsp_ok_ff;
   logic signed [TEMP_W-1:0] rsp_t_ff;
   logic [HUM_W-1:0]         rsp_h_ff;
   logic [PACK_W-1:0]        rsp_pack_ff, rsp_pack_in;

   // rounding
   logic              t_neg;
   logic [HUM_W-1:0]  t_mag, t_num, h_num;
   logic [RND_W-1:0]  t_prod, h_prod;
   logic [QUOT_W-1:0] t_quot, h_quot;
   logic signed [11:0] t_deci;
   logic [10:0]       t_unit;
   logic [9:0]        h_deci;

   assign busy  = reset;
   assign v0_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v0_ff         <= v0_in;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         rsp_strobe_ff <= v2_ff;
      end
   end

   always_comb begin
      crc_t1_in  = crc8_byte(CRC_INIT, raw_t0_ff[15:8]);
      crc_h1_in  = crc8_byte(CRC_INIT, raw_h0_ff[15:8]);
      prod_t1_in = PROD_W'(raw_t0_ff) * TEMP_SPAN;
      prod_h1_in = PROD_W'(raw_h0_ff) * HUM_SPAN;
   end

   hsfd_convert u_convert (
      .prod_temp   (prod_t1_ff),
      .prod_hum    (prod_h1_ff),
      .temp_scaled (t_conv),
      .hum_centi   (h_conv)
   );

   always_comb begin
      ok2_in = (crc8_byte(crc_t1_ff, lo_t1_ff) == chk_t1_ff) &&
               (crc8_byte(crc_h1_ff, lo_h1_ff) == chk_h1_ff);
      t_centi2_in = ok2_in ? t_conv : '0;
      h_centi2_in = ok2_in ? h_conv : '0;
   end

   // tenths: magnitude + 5, divided by ten through a reciprocal multiply, then clamped and packed
   always_comb begin
      t_neg  = t_centi2_ff[TEMP_W-1];
      t_mag  = t_neg ? HUM_W'(-t_centi2_ff) : HUM_W'(t_centi2_ff);
      t_num  = t_mag + ROUND_HALF;
      t_prod = RND_W'(t_num) * RND_W'(RECIP_TEN);
      t_quot = t_prod[RECIP_SHIFT +: QUOT_W];
      t_deci = t_neg ? -signed'({1'b0, t_quot}) : signed'({1'b0, t_quot});
      if (t_deci < TEMP_DECI_MIN) begin
         t_deci = TEMP_DECI_MIN;
      end else if (t_deci > TEMP_DECI_MAX) begin
         t_deci = TEMP_DECI_MAX;
      end
      t_unit = 11'(t_deci - TEMP_DECI_MIN);

      h_num  = h_centi2_ff + ROUND_HALF;
      h_prod = RND_W'(h_num) * RND_W'(RECIP_TEN);
      h_quot = h_prod[RECIP_SHIFT +: QUOT_W];
      if (h_quot > QUOT_W'(HUM_DECI_MAX)) begin
         h_deci = HUM_DECI_MAX;
      end else begin
         h_deci = h_quot[9:0];
      end

      rsp_pack_in = ok2_ff ? {3'b000, t_unit, h_deci} : INVALID_PACKED;
   end

   always_ff @(posedge clock) begin
      raw_t0_ff   <= req_raw_temperature;
      chk_t0_ff   <= req_temperature_check;
      raw_h0_ff   <= req_raw_humidity;
      chk_h0_ff   <= req_humidity_check;

      crc_t1_ff   <= crc_t1_in;
      crc_h1_ff   <= crc_h1_in;
      lo_t1_ff    <= raw_t0_ff[7:0];
      lo_h1_ff    <= raw_h0_ff[7:0];
      chk_t1_ff   <= chk_t0_ff;
      chk_h1_ff   <= chk_h0_ff;
      prod_t1_ff  <= prod_t1_in;
      prod_h1_ff  <= prod_h1_in;

      ok2_ff      <= ok2_in;
      t_centi2_ff <= t_centi2_in;
      h_centi2_ff <= h_centi2_in;

      rsp_ok_ff   <= ok2_ff;
      rsp_t_ff    <= t_centi2_ff;
      rsp_h_ff    <= h_centi2_ff;
      rsp_pack_ff <= rsp_pack_in;
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_check_ok          = rsp_ok_ff;
   assign rsp_temperature_centi = rsp_t_ff;
   assign rsp_humidity_centi    = rsp_h_ff;
   assign rsp_packed_reading    = rsp_pack_ff;

   `HSFD_ASSERT_NEXT(a_latency, start && !busy, ##3 rsp_strobe, "result beat not on time")
   `HSFD_ASSERT_SAME(a_fail_fields, rsp_strobe && !rsp_check_ok,
      rsp_packed_reading == INVALID_PACKED && rsp_temperature_centi == '0 &&
      rsp_humidity_centi == '0, "failed check beat carries data")
   `HSFD_ASSERT_SAME(a_hum_range, rsp_strobe && rsp_check_ok,
      rsp_humidity_centi <= HUM_CENTI_MAX && rsp_packed_reading[9:0] <= HUM_DECI_MAX,
      "humidity out of range")

endmodule

// File: test/testbench.sv
// self-checking testbench for the humidity sensor frame decoder
module testbench;
   import hsfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HUM_FIELD_W  = 10;
   localparam int MAX_REPORTED = 10;
   localparam int DRAIN_LIMIT  = 1000;
   localparam int QUIET_ITEMS  = 150;

   typedef struct packed {
      logic                     check_ok;
      logic signed [TEMP_W-1:0] temp_hundredths;
      logic [HUM_W-1:0]         hum_centi;
      logic [PACK_W-1:0]        packed_word;
   } reading_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [RAW_W-1:0]         req_raw_temperature = '0;
   logic [CRC_W-1:0]         req_temperature_check = '0;
   logic [RAW_W-1:0]         req_raw_humidity = '0;
   logic [CRC_W-1:0]         req_humidity_check = '0;
   logic                     rsp_strobe;
   logic                     rsp_check_ok;
   logic signed [TEMP_W-1:0] rsp_temperature_centi;
   logic [HUM_W-1:0]         rsp_humidity_centi;
   logic [PACK_W-1:0]        rsp_packed_reading;

   reading_t pending_readings[$];
   int       mismatch_count = 0;
   int       readouts_sent = 0;
   int       readouts_good = 0;
   int       readouts_checked = 0;

   humidity_sensor_frame_decode dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_raw_temperature   (req_raw_temperature),
      .req_temperature_check (req_temperature_check),
      .req_raw_humidity      (req_raw_humidity),
      .req_humidity_check    (req_humidity_check),
      .rsp_strobe            (rsp_strobe),
      .rsp_check_ok          (rsp_check_ok),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_packed_reading    (rsp_packed_reading)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // msb-first crc over the whole word, one bit per step
   function automatic logic [CRC_W-1:0] sensor_crc8(input logic [RAW_W-1:0] word);
      logic [CRC_W-1:0] crc;
      logic             fb;
      crc = CRC_INIT;
      for (int i = RAW_W - 1; i >= 0; i--) begin
         fb  = crc[CRC_W-1] ^ word[i];
         crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return crc;
   endfunction

   function automatic int scale_centi(input logic [RAW_W-1:0] raw, input longint span,
                                      input longint offset);
      longint num;
      num = span * longint'(raw) - offset * longint'(FULL_SCALE);
      return int'(num / longint'(FULL_SCALE));
   endfunction

   function automatic int temp_hundredths_of(input logic [RAW_W-1:0] raw);
      return scale_centi(raw, longint'(TEMP_SPAN), longint'(TEMP_OFFSET));
   endfunction

   function automatic int hum_centi_of(input logic [RAW_W-1:0] raw);
      int h;
      h = scale_centi(raw, longint'(HUM_SPAN), longint'(HUM_OFFSET));
      if (h < 0) h = 0;
      if (h > int'(HUM_CENTI_MAX)) h = int'(HUM_CENTI_MAX);
      return h;
   endfunction

   function automatic reading_t decode_reading(input logic [RAW_W-1:0] raw_t,
                                               input logic [CRC_W-1:0] chk_t,
                                               input logic [RAW_W-1:0] raw_h,
                                               input logic [CRC_W-1:0] chk_h);
      reading_t r;
      int       t_c;
      int       h_c;
      int       t_d;
      int       h_d;
      r.check_ok        = 1'b0;
      r.temp_hundredths = '0;
      r.hum_centi       = '0;
      r.packed_word     = INVALID_PACKED;
      if (sensor_crc8(raw_t) == chk_t && sensor_crc8(raw_h) == chk_h) begin
         t_c = temp_hundredths_of(raw_t);
         h_c = hum_centi_of(raw_h);
         // round half away from zero to tenths
         t_d = (t_c >= 0) ? (t_c + 5) / 10 : (t_c - 5) / 10;
         if (t_d < int'(TEMP_DECI_MIN)) t_d = int'(TEMP_DECI_MIN);
         if (t_d > int'(TEMP_DECI_MAX)) t_d = int'(TEMP_DECI_MAX);
         h_d = (h_c + int'(ROUND_HALF)) / 10;
         if (h_d > int'(HUM_DECI_MAX)) h_d = int'(HUM_DECI_MAX);
         r.check_ok        = 1'b1;
         r.temp_hundredths = t_c[TEMP_W-1:0];
         r.hum_centi       = h_c[HUM_W-1:0];
         r.packed_word     = PACK_W'(h_d[HUM_FIELD_W-1:0])
                           | (PACK_W'(t_d - int'(TEMP_DECI_MIN)) << HUM_FIELD_W);
      end
      return r;
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) $display("mismatch: %s", msg);
   endfunction

   // one beat on the request side, returns in the time step of its accept
   task automatic send_reading(input logic [RAW_W-1:0] raw_t, input logic [CRC_W-1:0] chk_t,
                               input logic [RAW_W-1:0] raw_h, input logic [CRC_W-1:0] chk_h);
      reading_t r;
      start                 <= 1'b1;
      req_raw_temperature   <= raw_t;
      req_temperature_check <= chk_t;
      req_raw_humidity      <= raw_h;
      req_humidity_check    <= chk_h;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = decode_reading(raw_t, chk_t, raw_h, chk_h);
      pending_readings.push_back(r);
      readouts_sent++;
      if (r.check_ok) readouts_good++;
   endtask

   task automatic send_valid(input logic [RAW_W-1:0] raw_t, input logic [RAW_W-1:0] raw_h);
      send_reading(raw_t, sensor_crc8(raw_t), raw_h, sensor_crc8(raw_h));
   endtask

   // idle gap with junk on the payload ports
   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_raw_temperature   <= RAW_W'($urandom);
         req_temperature_check <= CRC_W'($urandom);
         req_raw_humidity      <= RAW_W'($urandom);
         req_humidity_check    <= CRC_W'($urandom);
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      reading_t want;
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: ok=%0b t=%0d h=%0d p=%h",
                            rsp_check_ok, rsp_temperature_centi, rsp_humidity_centi,
                            rsp_packed_reading));
         end else begin
            want = pending_readings.pop_front();
            readouts_checked++;
            if (rsp_check_ok !== want.check_ok)
               report_mismatch($sformatf("check_ok exp %0b got %0b",
                               want.check_ok, rsp_check_ok));
            if (rsp_temperature_centi !== want.temp_hundredths)
               report_mismatch($sformatf("temperature_centi exp %0d got %0d",
                               want.temp_hundredths, rsp_temperature_centi));
            if (rsp_humidity_centi !== want.hum_centi)
               report_mismatch($sformatf("humidity_centi exp %0d got %0d",
                               want.hum_centi, rsp_humidity_centi));
            if (rsp_packed_reading !== want.packed_word)
               report_mismatch($sformatf("packed_reading exp %h got %h",
                               want.packed_word, rsp_packed_reading));
         end
      end
   end

   task automatic test_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_extremes();
      send_valid(16'h0000, 16'h0000);
      send_valid(16'hFFFF, 16'hFFFF);
      send_valid(16'h0000, 16'hFFFF);
      send_valid(16'hFFFF, 16'h0000);
      send_valid(16'h6666, 16'h8000);
   endtask

   task automatic test_check_failures();
      send_reading(16'h6666, sensor_crc8(16'h6666) ^ 8'h01, 16'h8000, sensor_crc8(16'h8000));
      send_reading(16'h6666, sensor_crc8(16'h6666), 16'h8000, sensor_crc8(16'h8000) ^ 8'h80);
      send_reading(16'hFFFF, ~sensor_crc8(16'hFFFF), 16'h0000, ~sensor_crc8(16'h0000));
      pause_sender(3);
      send_reading(16'h1234, 8'h00, 16'hABCD, 8'hFF);
   endtask

   task automatic test_humidity_clamps();
      // below zero until raw 3146, full scale from raw 55574
      send_valid(16'h4000, 16'd1000);
      send_valid(16'h4000, 16'd3145);
      send_valid(16'h4000, 16'd3146);
      send_valid(16'h4000, 16'd55573);
      send_valid(16'h4000, 16'd55574);
      send_valid(16'h4000, 16'd60000);
   endtask

   task automatic test_cold_and_rounding();
      logic [RAW_W-1:0] pos_half;
      logic [RAW_W-1:0] neg_half;
      logic [RAW_W-1:0] hum_half;
      bit               got_pos;
      bit               got_neg;
      bit               got_hum;
      int               t_c;
      int               h_c;
      got_pos = 0;
      got_neg = 0;
      got_hum = 0;
      pos_half = '0;
      neg_half = '0;
      hum_half = '0;
      // raw words whose centi value sits exactly on a half tenth
      for (int raw = 0; raw < 65536; raw++) begin
         t_c = temp_hundredths_of(RAW_W'(raw));
         h_c = hum_centi_of(RAW_W'(raw));
         if (!got_pos && t_c > 0 && t_c % 10 == 5) begin
            pos_half = RAW_W'(raw);
            got_pos = 1;
         end
         if (!got_neg && t_c < 0 && t_c % 10 == -5) begin
            neg_half = RAW_W'(raw);
            got_neg = 1;
         end
         if (!got_hum && h_c > 0 && h_c < int'(HUM_CENTI_MAX) && h_c % 10 == 5) begin
            hum_half = RAW_W'(raw);
            got_hum = 1;
         end
      end
      send_valid(16'd1000, 16'h7000);
      send_valid(16'd1872, 16'h7000);
      send_valid(16'd1873, 16'h7000);
      send_valid(pos_half, hum_half);
      send_valid(neg_half, hum_half);
   endtask

   task automatic test_random_readouts(input int count);
      logic [RAW_W-1:0] raw_t;
      logic [RAW_W-1:0] raw_h;
      logic [CRC_W-1:0] chk_t;
      logic [CRC_W-1:0] chk_h;
      int               idle_mode;
      int               kind;
      idle_mode = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) idle_mode = $urandom_range(0, 2);
         raw_t = RAW_W'($urandom);
         raw_h = RAW_W'($urandom);
         // lean toward the clamp regions now and then
         if ($urandom_range(0, 4) == 0) raw_t = RAW_W'($urandom_range(0, 3000));
         if ($urandom_range(0, 4) == 0)
            raw_h = $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 3500))
                                         : RAW_W'($urandom_range(55000, 65535));
         chk_t = sensor_crc8(raw_t);
         chk_h = sensor_crc8(raw_h);
         kind = $urandom_range(0, 9);
         if (kind == 7) chk_t = chk_t ^ CRC_W'($urandom_range(1, 255));
         if (kind == 8) chk_h = chk_h ^ CRC_W'($urandom_range(1, 255));
         if (kind == 9) begin
            chk_t = CRC_W'($urandom);
            chk_h = CRC_W'($urandom);
         end
         send_reading(raw_t, chk_t, raw_h, chk_h);
         if (i < count - QUIET_ITEMS && idle_mode != 0
             && $urandom_range(0, idle_mode == 1 ? 5 : 1) == 0)
            pause_sender($urandom_range(1, 6));
      end
      start <= 1'b0;
   endtask

   initial begin
      int waited;
      test_reset();
      test_extremes();
      test_check_failures();
      test_humidity_clamps();
      test_cold_and_rounding();
      test_random_readouts(880);
      waited = 0;
      while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_readings.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
      $display("sent %0d readouts (%0d with good crc bytes, %0d rejected), checked %0d results",
               readouts_sent, readouts_good, readouts_sent - readouts_good, readouts_checked);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
